>>> sv/mmsf_pkg.sv
package mmsf_pkg;

  localparam int PressW     = 18;
  localparam int TotalW     = 24;
  localparam int LenW       = 6;
  localparam int LenReset   = 21;
  localparam int MedTaps    = 3;
  localparam int MedIdxW    = 2;
  localparam int MaxWindow  = 63;
  localparam int StoreSlots = MaxWindow + 1;
  localparam int WinIdxW    = $clog2(StoreSlots);

  typedef logic [PressW-1:0] press_t;
  typedef logic [TotalW-1:0] total_t;
  typedef logic [LenW-1:0]   len_t;

  // One filtered sample on its way from the window stage to the output stage.
  typedef struct packed {
    press_t filt;
    press_t sub;
    logic   full;
  } win_item_t;

endpackage

>>> sv/mmsf_median.sv
module mmsf_median (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  mmsf_pkg::press_t sample,
  output mmsf_pkg::press_t filt
);
  import mmsf_pkg::*;

  press_t                ring_r [MedTaps];
  logic   [MedIdxW-1:0]  idx_r;
  logic   [MedIdxW-1:0]  idx_nxt;
  logic                  ready_r;
  logic                  ready_nxt;
  logic   [MedIdxW-1:0]  pos;
  logic   [MedIdxW-1:0]  step;
  logic                  wrap;
  press_t                tap_a;
  press_t                tap_b;
  press_t                tap_c;

  function automatic press_t mid3(press_t a, press_t b, press_t c);
    press_t lo;
    press_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

  always_comb begin
    pos       = (idx_r >= MedIdxW'(MedTaps)) ? '0 : idx_r;
    step      = pos + 1'b1;
    wrap      = (step >= MedIdxW'(MedTaps));
    idx_nxt   = wrap ? '0 : step;
    ready_nxt = ready_r | wrap;
    // The new sample takes its slot before the median is formed.
    tap_a     = (pos == MedIdxW'(0)) ? sample : ring_r[0];
    tap_b     = (pos == MedIdxW'(1)) ? sample : ring_r[1];
    tap_c     = (pos == MedIdxW'(2)) ? sample : ring_r[2];
    filt      = ready_nxt ? mid3(tap_a, tap_b, tap_c) : sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      ready_r <= 1'b0;
    end else if (accept) begin
      idx_r   <= idx_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_r[pos] <= sample;
    end
  end

endmodule

>>> sv/mmsf_window.sv
module mmsf_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  mmsf_pkg::press_t    filt,
  input  mmsf_pkg::len_t      win_len,
  input  logic                take,
  output logic                s1_valid,
  output mmsf_pkg::win_item_t s1_item
);
  import mmsf_pkg::*;

  press_t               mem [StoreSlots];
  logic                 vld_r [StoreSlots];
  logic   [WinIdxW-1:0] idx_r;
  logic   [WinIdxW-1:0] idx_nxt;
  logic                 ready_r;
  logic                 ready_nxt;
  logic   [WinIdxW-1:0] len_eff;
  logic                 s1_valid_r;
  press_t               s1_filt_r;
  logic                 s1_full_r;
  logic                 s1_self_r;
  press_t               rd_r;
  logic                 rd_vld_r;

  always_comb begin
    len_eff   = (int'(win_len) > MaxWindow) ? WinIdxW'(MaxWindow) : WinIdxW'(win_len);
    ready_nxt = ready_r | (idx_r >= len_eff);
    idx_nxt   = (idx_r >= len_eff) ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      ready_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r      <= idx_nxt;
        ready_r    <= ready_nxt;
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Valid bits stand in for the all-zero reset of the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < StoreSlots; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (accept) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // Write the new slot and read the slot to retire in the same cycle. Only a
  // zero-length window reads the slot being written; that case is flagged.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[idx_r] <= filt;
      rd_r       <= mem[idx_nxt];
      rd_vld_r   <= vld_r[idx_nxt];
      s1_filt_r  <= filt;
      s1_full_r  <= ready_nxt;
      s1_self_r  <= (idx_nxt == idx_r);
    end
  end

  always_comb begin
    s1_valid     = s1_valid_r;
    s1_item.filt = s1_filt_r;
    s1_item.full = s1_full_r;
    if (s1_self_r) begin
      s1_item.sub = s1_filt_r;
    end else if (rd_vld_r) begin
      s1_item.sub = rd_r;
    end else begin
      s1_item.sub = '0;
    end
  end

endmodule

>>> sv/mmsf_total.sv
module mmsf_total (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  mmsf_pkg::win_item_t s1_item,
  input  logic                out_stall,
  output logic                take,
  output logic                out_valid,
  output mmsf_pkg::press_t    out_filt,
  output mmsf_pkg::total_t    out_total,
  output logic                out_full
);
  import mmsf_pkg::*;

  logic   out_valid_r;
  press_t filt_r;
  logic   full_r;
  total_t total_r;
  total_t total_nxt;

  assign take      = s1_valid && (!out_valid_r || !out_stall);
  assign total_nxt = total_r + TotalW'(s1_item.filt) - TotalW'(s1_item.sub);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else if (take) begin
      out_valid_r <= 1'b1;
      total_r     <= total_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      filt_r <= s1_item.filt;
      full_r <= s1_item.full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_filt  = filt_r;
  assign out_total = total_r;
  assign out_full  = full_r;

endmodule

>>> sv/median3_moving_sum_filter_core.sv
// Pressure smoother: a median-of-three filter followed by a moving-window sum.
// Each input transaction carries one pressure sample and produces exactly one
// output transaction with the filtered sample, the running total of the last
// window_length filtered samples and the window_full flag. The block accepts
// one transaction per clock cycle while in_stall is low; an accepted input
// passes the window stage, which reads the window memory, and then the output
// register. The filtered samples live in a 64-slot synchronous memory with
// one write port and one read port that writes the new slot and reads the
// slot to retire in the same cycle; per-slot valid bits stand for its all-zero
// reset, so there is no clearing pass and the block takes input right out of
// reset. window_length is written through cfg_wr_en/cfg_wr_data and resets to
// 21; change it only while the block is idle.
module median3_moving_sum_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  mmsf_pkg::len_t      cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmsf_pkg::press_t    in_pressure,
  output logic                out_valid,
  input  logic                out_stall,
  output mmsf_pkg::press_t    out_filtered_pressure,
  output mmsf_pkg::total_t    out_pressure_total,
  output logic                out_window_full
);
  import mmsf_pkg::*;

  len_t      win_len_r;
  logic      accept;
  logic      take;
  logic      s1_valid;
  win_item_t s1_item;
  press_t    filt;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= len_t'(LenReset);
    end else if (cfg_wr_en) begin
      win_len_r <= cfg_wr_data;
    end
  end

  // The window stage holds one sample; it stalls the input only while its
  // sample cannot move into the output register.
  assign in_stall = s1_valid && !take;
  assign accept   = in_valid && !in_stall;

  // Median of the last three samples at acceptance; the first two pass through.
  mmsf_median u_median (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (in_pressure),
    .filt   (filt)
  );

  // Window index, store and the read of the slot that leaves the window.
  mmsf_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .filt     (filt),
    .win_len  (win_len_r),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Running total update and the output register.
  mmsf_total u_total (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .out_filt  (out_filtered_pressure),
    .out_total (out_pressure_total),
    .out_full  (out_window_full)
  );

endmodule

>>> sv/mmsf_checker.sv
module mmsf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input mmsf_pkg::press_t out_filtered_pressure,
  input mmsf_pkg::total_t out_pressure_total,
  input logic             out_window_full
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_pressure)
      && $stable(out_pressure_total) && $stable(out_window_full))
    else $error("stalled result changed");

  // The input is held back only by a stalled, occupied output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // After acceptance, out_valid is up past window and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result did not arrive");

  // Once the window has wrapped, later results keep the flag.
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_full |=> !out_valid || out_window_full)
    else $error("window_full dropped");

endmodule

bind median3_moving_sum_filter_core mmsf_checker u_mmsf_checker (.*);
